[hw/rtl/jdcd_pkg.sv]
// Shared constants, types and tables for the day-number-to-date converter.
`timescale 1ns / 1ps

package jdcd_pkg;

  localparam int DAY_BITS    = 31;
  localparam int IN_TDATA_W  = ((DAY_BITS + 7) / 8) * 8;
  localparam int DAY_W       = 5;
  localparam int MON_W       = 4;
  localparam int YEAR_W      = 23;
  localparam int OUT_TDATA_W = ((DAY_W + MON_W + YEAR_W + 1 + 7) / 8) * 8;

  // Calendar landmarks, in days from day zero
  localparam int JUL_1582    = 2298884;   // 1 Jan 1582
  localparam int GREG_START  = 2299239;   // 1 Jan 1583
  localparam int GREG_REBASE = 139522;    // 1 Jan 1201 .. 1 Jan 1583, Gregorian

  localparam int JUL_CYCLE   = 1461;
  localparam int GREG_CYCLE  = 146097;
  localparam int CENT_DAYS   = 36524;
  localparam int BC_LAST     = 4712;      // 4*q+s up to this is BC
  localparam int GREG_BASE_YEAR = 1201;

  // Julian split: k < 2^22, k/1461 by reciprocal
  localparam int JK_W        = 22;
  localparam int JQ_W        = 11;
  localparam int JR_W        = 12;
  localparam int JDIV_SHIFT  = JK_W + 1;
  localparam int JREC_W      = 13;
  localparam int JDIV_RECIP  = (1 << JDIV_SHIFT) / JUL_CYCLE;

  // Gregorian split: g < 2^GW, g/146097 by reciprocal
  localparam int GW          = DAY_BITS + 1;
  localparam int GDIV_SHIFT  = GW + 1;
  localparam int GREC_W      = GDIV_SHIFT - 16;
  localparam int GQ_W        = GW - 16;
  localparam longint unsigned GDIV_RECIP = (64'd1 << GDIV_SHIFT) / GREG_CYCLE;
  localparam int GR_W        = 19;
  localparam int GRC_W       = 18;

  // Four-year groups inside a century
  localparam int R2_W        = 16;
  localparam int DDIV_SHIFT  = 17;
  localparam int DREC_W      = 7;
  localparam int DDIV_RECIP  = (1 << DDIV_SHIFT) / JUL_CYCLE;
  localparam int DQ_W        = 5;
  localparam int R3_W        = 11;

  localparam int OFF_W       = 9;
  localparam logic [3:0] MON_OCT = 4'd9;   // zero-based October

  typedef struct packed {
    logic [OFF_W-1:0] offset;   // day within year, from 0
    logic             leap;
    logic             oct1582;  // year 1582 with the short October
  } day_pos_t;

  // First day offset of zero-based month m
  function automatic logic [OFF_W-1:0] month_start(input logic [3:0] m, input logic leap,
                                                   input logic oct1582);
    logic [OFF_W-1:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = oct1582 ? 9'd294 : 9'd304;
      4'd11:   s = oct1582 ? 9'd324 : 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) s = s + 9'd1;
    return s;
  endfunction

endpackage

[hw/rtl/jdcd_month_split.sv]
// Splits a day offset within a year into month and day of month.
`timescale 1ns / 1ps

module jdcd_month_split (
  input  jdcd_pkg::day_pos_t               pos_i,
  output logic [jdcd_pkg::DAY_W-1:0]       day_o,
  output logic [jdcd_pkg::MON_W-1:0]       month_o
);

  logic [3:0]                   mon;
  logic [jdcd_pkg::OFF_W-1:0]   start;
  logic [jdcd_pkg::DAY_W-1:0]   d0;

  always_comb begin
    mon = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (jdcd_pkg::month_start(4'(i), pos_i.leap, pos_i.oct1582) <= pos_i.offset) begin
        mon = mon + 4'd1;
      end
    end
    start = jdcd_pkg::month_start(mon, pos_i.leap, pos_i.oct1582);
    d0    = jdcd_pkg::DAY_W'(pos_i.offset - start);
    day_o = d0 + 5'd1;
    // short October of 1582: the 5th to the 14th do not exist
    if (pos_i.oct1582 && (mon == jdcd_pkg::MON_OCT) && (d0 >= 5'd4)) begin
      day_o = d0 + 5'd11;
    end
    month_o = mon + 4'd1;
  end

endmodule

[hw/rtl/julian_day_to_calendar_date_unit.sv]
// Top level: pipelined day-number to calendar-date converter.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one beat per day number (days since 1 Jan 4713 BC), low
//   DAY_BITS bits of s_axis_tdata_i; bits above are ignored.
//   Master stream: one beat per input beat, in order, carrying day, month,
//   year and a BC flag. Julian calendar up to 4 Oct 1582, Gregorian from
//   15 Oct 1582 on.
// Timing
//   Ten register stages. One beat per cycle sustained while the master
//   side is ready. The stage count is set by the divider chain: a
//   reciprocal multiply, a remainder and a correction per division,
//   done twice in series.
// Reset
//   rst_ni clears all stage valid bits; the pipeline comes up empty.
// Stall
//   Each full stage holds while the one after it is full and not moving, so a
//   stalled receiver fills bubbles first, then back-pressures the slave side.
//   Nothing is dropped or repeated.

module julian_day_to_calendar_date_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // s_axis_tdata_i: [DAY_BITS-1:0] day_number
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [jdcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // m_axis_tdata_o: [4:0] day_of_month, [8:5] month_number,
  //                 [31:9] year_number, [32] before_christ
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [jdcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int NST = 10;
  localparam int GW  = jdcd_pkg::GW;
  localparam int YW  = jdcd_pkg::YEAR_W;

  logic [NST-1:0] v_q;
  logic [NST:0]   adv;

  // stage i loads when empty or when its successor moves
  always_comb begin
    adv[NST] = m_axis_tready_i;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ---------------- stage 0: capture
  logic [jdcd_pkg::DAY_BITS-1:0] s0_k_q;

  // ---------------- stage 1: classify, rebase
  logic                          s1_jul_d, s1_oct_d;
  logic                          s1_jul_q, s1_oct_q;
  logic [jdcd_pkg::JK_W-1:0]     s1_jk_q;
  logic [GW-1:0]                 s1_g_d, s1_g_q;

  always_comb begin
    s1_jul_d = s0_k_q < jdcd_pkg::DAY_BITS'(jdcd_pkg::GREG_START);
    s1_oct_d = s1_jul_d && (s0_k_q >= jdcd_pkg::DAY_BITS'(jdcd_pkg::JUL_1582));
    // days since 1 Jan 1201 on the Gregorian grid
    s1_g_d   = GW'(s0_k_q) - GW'(jdcd_pkg::GREG_START - jdcd_pkg::GREG_REBASE);
  end

  // ---------------- stage 2: reciprocal multiplies
  logic [jdcd_pkg::JK_W+jdcd_pkg::JREC_W-1:0] jprod;
  logic [GW+jdcd_pkg::GREC_W-1:0]             gprod;
  logic                          s2_jul_q, s2_oct_q;
  logic [jdcd_pkg::JK_W-1:0]     s2_jk_q;
  logic [GW-1:0]                 s2_g_q;
  logic [jdcd_pkg::JQ_W-1:0]     s2_jq_q;
  logic [jdcd_pkg::GQ_W-1:0]     s2_gq_q;

  assign jprod = (jdcd_pkg::JK_W + jdcd_pkg::JREC_W)'(s1_jk_q)
               * (jdcd_pkg::JK_W + jdcd_pkg::JREC_W)'(jdcd_pkg::JDIV_RECIP);
  assign gprod = (GW + jdcd_pkg::GREC_W)'(s1_g_q)
               * (GW + jdcd_pkg::GREC_W)'(jdcd_pkg::GDIV_RECIP);

  // ---------------- stage 3: raw remainders
  logic [jdcd_pkg::JK_W-1:0]     jsub;
  logic [GW-1:0]                 gsub;
  logic                          s3_jul_q, s3_oct_q;
  logic [jdcd_pkg::JQ_W-1:0]     s3_jq_q;
  logic [jdcd_pkg::GQ_W-1:0]     s3_gq_q;
  logic [jdcd_pkg::JR_W-1:0]     s3_jr_q;
  logic [jdcd_pkg::GR_W-1:0]     s3_gr_q;

  assign jsub = s2_jk_q - jdcd_pkg::JK_W'(jdcd_pkg::JK_W'(s2_jq_q)
                                          * jdcd_pkg::JK_W'(jdcd_pkg::JUL_CYCLE));
  assign gsub = s2_g_q - GW'(GW'(s2_gq_q) * GW'(jdcd_pkg::GREG_CYCLE));

  // ---------------- stage 4: quotient correction
  logic                          s4_jul_q, s4_oct_q;
  logic [jdcd_pkg::JQ_W-1:0]     s4_jq_d, s4_jq_q;
  logic [jdcd_pkg::GQ_W-1:0]     s4_gq_d, s4_gq_q;
  logic [jdcd_pkg::JR_W-2:0]     s4_jr_d, s4_jr_q;
  logic [jdcd_pkg::GRC_W-1:0]    s4_gr_d, s4_gr_q;

  always_comb begin
    s4_jq_d = s3_jq_q;
    s4_jr_d = (jdcd_pkg::JR_W-1)'(s3_jr_q);
    if (s3_jr_q >= jdcd_pkg::JR_W'(jdcd_pkg::JUL_CYCLE)) begin
      s4_jq_d = s3_jq_q + 1'b1;
      s4_jr_d = (jdcd_pkg::JR_W-1)'(s3_jr_q - jdcd_pkg::JR_W'(jdcd_pkg::JUL_CYCLE));
    end
    s4_gq_d = s3_gq_q;
    s4_gr_d = jdcd_pkg::GRC_W'(s3_gr_q);
    if (s3_gr_q >= jdcd_pkg::GR_W'(jdcd_pkg::GREG_CYCLE)) begin
      s4_gq_d = s3_gq_q + 1'b1;
      s4_gr_d = jdcd_pkg::GRC_W'(s3_gr_q - jdcd_pkg::GR_W'(jdcd_pkg::GREG_CYCLE));
    end
  end

  // ---------------- stage 5: century / Julian year in group
  logic                          s5_jul_q, s5_oct_q;
  logic [1:0]                    s5_c_d, s5_c_q;
  logic [jdcd_pkg::R2_W-1:0]     s5_r2_d, s5_r2_q;
  logic [YW-1:0]                 s5_gyb_d, s5_gyb_q;
  logic [jdcd_pkg::GQ_W+YW-1:0]  gyb_full;
  logic [1:0]                    s5_js_d, s5_js_q;
  logic [jdcd_pkg::OFF_W-1:0]    s5_jo_d, s5_jo_q;
  logic [jdcd_pkg::JQ_W+1:0]     s5_t_d, s5_t_q;

  always_comb begin
    if (s4_gr_q < jdcd_pkg::GRC_W'(jdcd_pkg::CENT_DAYS))          s5_c_d = 2'd0;
    else if (s4_gr_q < jdcd_pkg::GRC_W'(2 * jdcd_pkg::CENT_DAYS)) s5_c_d = 2'd1;
    else if (s4_gr_q < jdcd_pkg::GRC_W'(3 * jdcd_pkg::CENT_DAYS)) s5_c_d = 2'd2;
    else                                                           s5_c_d = 2'd3;
    s5_r2_d  = jdcd_pkg::R2_W'(s4_gr_q - jdcd_pkg::GRC_W'(s5_c_d)
                                         * jdcd_pkg::GRC_W'(jdcd_pkg::CENT_DAYS));
    gyb_full = (jdcd_pkg::GQ_W + YW)'(s4_gq_q) * (jdcd_pkg::GQ_W + YW)'(400)
             + (jdcd_pkg::GQ_W + YW)'(jdcd_pkg::GREG_BASE_YEAR);
    s5_gyb_d = gyb_full[YW-1:0];
    // Julian group starts with its leap year: 366, 365, 365, 365
    if (s4_jr_q < 11'd366) begin
      s5_js_d = 2'd0; s5_jo_d = jdcd_pkg::OFF_W'(s4_jr_q);
    end else if (s4_jr_q < 11'd731) begin
      s5_js_d = 2'd1; s5_jo_d = jdcd_pkg::OFF_W'(s4_jr_q - 11'd366);
    end else if (s4_jr_q < 11'd1096) begin
      s5_js_d = 2'd2; s5_jo_d = jdcd_pkg::OFF_W'(s4_jr_q - 11'd731);
    end else begin
      s5_js_d = 2'd3; s5_jo_d = jdcd_pkg::OFF_W'(s4_jr_q - 11'd1096);
    end
    s5_t_d = {s4_jq_q, 2'b00} + (jdcd_pkg::JQ_W + 2)'(s5_js_d);
  end

  // ---------------- stage 6: four-year group multiply, Julian year
  logic [jdcd_pkg::R2_W+jdcd_pkg::DREC_W-1:0] dprod;
  logic                          s6_jul_q, s6_oct_q;
  logic [1:0]                    s6_c_q;
  logic [jdcd_pkg::R2_W-1:0]     s6_r2_q;
  logic [jdcd_pkg::DQ_W-1:0]     s6_dq_q;
  logic [YW-1:0]                 s6_gy_d, s6_gy_q;
  logic                          s6_jbc_d, s6_jbc_q;
  logic [jdcd_pkg::JQ_W+1:0]     s6_jy_d, s6_jy_q;
  logic                          s6_jleap_q;
  logic [jdcd_pkg::OFF_W-1:0]    s6_jo_q;

  assign dprod = (jdcd_pkg::R2_W + jdcd_pkg::DREC_W)'(s5_r2_q)
               * (jdcd_pkg::R2_W + jdcd_pkg::DREC_W)'(jdcd_pkg::DDIV_RECIP);

  always_comb begin
    s6_gy_d  = s5_gyb_q + YW'(s5_c_q) * YW'(100);
    s6_jbc_d = s5_t_q <= (jdcd_pkg::JQ_W + 2)'(jdcd_pkg::BC_LAST);
    s6_jy_d  = s6_jbc_d ? (jdcd_pkg::JQ_W + 2)'(jdcd_pkg::BC_LAST + 1) - s5_t_q
                        : s5_t_q - (jdcd_pkg::JQ_W + 2)'(jdcd_pkg::BC_LAST);
  end

  // ---------------- stage 7: group remainder and correction
  logic [jdcd_pkg::R2_W-1:0]     r3raw;
  logic                          s7_jul_q, s7_oct_q;
  logic [1:0]                    s7_c_q;
  logic [jdcd_pkg::DQ_W-1:0]     s7_d_d, s7_d_q;
  logic [jdcd_pkg::R3_W-1:0]     s7_r3_d, s7_r3_q;
  logic [YW-1:0]                 s7_gy_q;
  logic                          s7_jbc_q, s7_jleap_q;
  logic [jdcd_pkg::JQ_W+1:0]     s7_jy_q;
  logic [jdcd_pkg::OFF_W-1:0]    s7_jo_q;

  always_comb begin
    r3raw   = s6_r2_q - jdcd_pkg::R2_W'(jdcd_pkg::R2_W'(s6_dq_q)
                                        * jdcd_pkg::R2_W'(jdcd_pkg::JUL_CYCLE));
    s7_d_d  = s6_dq_q;
    s7_r3_d = jdcd_pkg::R3_W'(r3raw);
    if (r3raw >= jdcd_pkg::R2_W'(jdcd_pkg::JUL_CYCLE)) begin
      s7_d_d  = s6_dq_q + 1'b1;
      s7_r3_d = jdcd_pkg::R3_W'(r3raw - jdcd_pkg::R2_W'(jdcd_pkg::JUL_CYCLE));
    end
  end

  // ---------------- stage 8: year in group, merge calendars
  logic [1:0]                    gy_in;
  logic [jdcd_pkg::OFF_W-1:0]    go;
  jdcd_pkg::day_pos_t            s8_pos_d, s8_pos_q;
  logic [YW-1:0]                 s8_year_d, s8_year_q;
  logic                          s8_bc_d, s8_bc_q;

  always_comb begin
    // Gregorian group: 365, 365, 365, then 366 unless a plain century year
    if (s7_r3_q < 11'd365) begin
      gy_in = 2'd0; go = jdcd_pkg::OFF_W'(s7_r3_q);
    end else if (s7_r3_q < 11'd730) begin
      gy_in = 2'd1; go = jdcd_pkg::OFF_W'(s7_r3_q - 11'd365);
    end else if (s7_r3_q < 11'd1095) begin
      gy_in = 2'd2; go = jdcd_pkg::OFF_W'(s7_r3_q - 11'd730);
    end else begin
      gy_in = 2'd3; go = jdcd_pkg::OFF_W'(s7_r3_q - 11'd1095);
    end
    s8_pos_d.oct1582 = s7_oct_q;
    if (s7_jul_q) begin
      s8_pos_d.offset = s7_jo_q;
      s8_pos_d.leap   = s7_jleap_q && !s7_oct_q;
      s8_year_d       = YW'(s7_jy_q);
      s8_bc_d         = s7_jbc_q;
    end else begin
      s8_pos_d.offset = go;
      s8_pos_d.leap   = (gy_in == 2'd3) && ((s7_d_q != 5'd24) || (s7_c_q == 2'd3));
      s8_year_d       = s7_gy_q + YW'({s7_d_q, 2'b00}) + YW'(gy_in);
      s8_bc_d         = 1'b0;
    end
  end

  // ---------------- stage 9: month split, output register
  logic [jdcd_pkg::DAY_W-1:0]    day_d, s9_day_q;
  logic [jdcd_pkg::MON_W-1:0]    mon_d, s9_mon_q;
  logic [YW-1:0]                 s9_year_q;
  logic                          s9_bc_q;

  jdcd_month_split u_split (
    .pos_i   (s8_pos_q),
    .day_o   (day_d),
    .month_o (mon_d)
  );

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (adv[0]) s0_k_q <= s_axis_tdata_i[jdcd_pkg::DAY_BITS-1:0];
    if (adv[1]) begin
      s1_jul_q <= s1_jul_d;
      s1_oct_q <= s1_oct_d;
      s1_jk_q  <= s0_k_q[jdcd_pkg::JK_W-1:0];
      s1_g_q   <= s1_g_d;
    end
    if (adv[2]) begin
      s2_jul_q <= s1_jul_q;
      s2_oct_q <= s1_oct_q;
      s2_jk_q  <= s1_jk_q;
      s2_g_q   <= s1_g_q;
      s2_jq_q  <= jprod[jdcd_pkg::JDIV_SHIFT +: jdcd_pkg::JQ_W];
      s2_gq_q  <= gprod[jdcd_pkg::GDIV_SHIFT +: jdcd_pkg::GQ_W];
    end
    if (adv[3]) begin
      s3_jul_q <= s2_jul_q;
      s3_oct_q <= s2_oct_q;
      s3_jq_q  <= s2_jq_q;
      s3_gq_q  <= s2_gq_q;
      s3_jr_q  <= jsub[jdcd_pkg::JR_W-1:0];
      s3_gr_q  <= gsub[jdcd_pkg::GR_W-1:0];
    end
    if (adv[4]) begin
      s4_jul_q <= s3_jul_q;
      s4_oct_q <= s3_oct_q;
      s4_jq_q  <= s4_jq_d;
      s4_gq_q  <= s4_gq_d;
      s4_jr_q  <= s4_jr_d;
      s4_gr_q  <= s4_gr_d;
    end
    if (adv[5]) begin
      s5_jul_q <= s4_jul_q;
      s5_oct_q <= s4_oct_q;
      s5_c_q   <= s5_c_d;
      s5_r2_q  <= s5_r2_d;
      s5_gyb_q <= s5_gyb_d;
      s5_js_q  <= s5_js_d;
      s5_jo_q  <= s5_jo_d;
      s5_t_q   <= s5_t_d;
    end
    if (adv[6]) begin
      s6_jul_q   <= s5_jul_q;
      s6_oct_q   <= s5_oct_q;
      s6_c_q     <= s5_c_q;
      s6_r2_q    <= s5_r2_q;
      s6_dq_q    <= dprod[jdcd_pkg::DDIV_SHIFT +: jdcd_pkg::DQ_W];
      s6_gy_q    <= s6_gy_d;
      s6_jbc_q   <= s6_jbc_d;
      s6_jy_q    <= s6_jy_d;
      s6_jleap_q <= (s5_js_q == 2'd0);
      s6_jo_q    <= s5_jo_q;
    end
    if (adv[7]) begin
      s7_jul_q   <= s6_jul_q;
      s7_oct_q   <= s6_oct_q;
      s7_c_q     <= s6_c_q;
      s7_d_q     <= s7_d_d;
      s7_r3_q    <= s7_r3_d;
      s7_gy_q    <= s6_gy_q;
      s7_jbc_q   <= s6_jbc_q;
      s7_jleap_q <= s6_jleap_q;
      s7_jy_q    <= s6_jy_q;
      s7_jo_q    <= s6_jo_q;
    end
    if (adv[8]) begin
      s8_pos_q  <= s8_pos_d;
      s8_year_q <= s8_year_d;
      s8_bc_q   <= s8_bc_d;
    end
    if (adv[9]) begin
      s9_day_q  <= day_d;
      s9_mon_q  <= mon_d;
      s9_year_q <= s8_year_q;
      s9_bc_q   <= s8_bc_q;
    end
  end

  assign m_axis_tdata_o = jdcd_pkg::OUT_TDATA_W'({s9_bc_q, s9_year_q, s9_mon_q, s9_day_q});

endmodule

[hw/rtl/jdcd_checker.sv]
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps

module jdcd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [jdcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output beat changed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[4:0] != 5'd0) && (m_axis_tdata_o[8:5] != 4'd0)
                        && (m_axis_tdata_o[8:5] <= 4'd12) && (m_axis_tdata_o[31:9] != 23'd0))
    else $error("date field out of range");

  a_bc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32] |-> m_axis_tdata_o[31:9] <= 23'd4713)
    else $error("BC year beyond 4713");

  a_rst: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind julian_day_to_calendar_date_unit jdcd_checker u_jdcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
